[hw/rtl/aprc_pkg.sv]
// shared types, widths and helpers for the aabb pair resolver
// no dependencies; imported by every module of the block
package aprc_pkg;

  // component and field widths fixed by the packed beat layout
  localparam int CoordBits = 16;
  localparam int MassBits  = 16;
  localparam int VecBits   = 3 * CoordBits;
  localparam int NumAxes   = 3;

  // internal arithmetic widths
  localparam int ExtBits   = CoordBits + 2;   // box extents
  localparam int OverBits  = CoordBits + 3;   // per-axis overlap
  localparam int ProdBits  = MassBits + CoordBits + 1;
  localparam int NumBits   = ProdBits + 1;    // signed momentum sum
  localparam int MagBits   = NumBits - 2;     // magnitude of momentum sum
  localparam int DenBits   = MassBits + 1;    // total mass
  localparam int QuotBits  = CoordBits;       // |vcm| never above 2^(CoordBits-1)
  localparam int VcmBits   = CoordBits + 1;
  localparam int WideBits  = CoordBits + 4;   // pre-saturation result

  // pipeline depth: one product stage, one sum stage, one stage per quotient bit
  localparam int DivStages = QuotBits;
  localparam int DlyStages = DivStages + 1;
  localparam int Latency   = DlyStages + 1;

  // beat widths
  localparam int InBits  = 6 * VecBits + 2 * MassBits + 2;
  localparam int InBytes = (InBits + 7) / 8;
  localparam int OutBits = 1 + 4 * VecBits + 2;
  localparam int OutBytes = (OutBits + 7) / 8;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } push_axis_e;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic signed [CoordBits-1:0] ca;
    logic signed [CoordBits-1:0] cb;
    logic signed [CoordBits-1:0] va;
    logic signed [CoordBits-1:0] vb;
    logic signed [OverBits-1:0]  over;
    logic                        hit;
    logic signed [VcmBits-1:0]   vcm;
  } lane_res_t;

  // data carried alongside the divider
  typedef struct packed {
    logic signed [CoordBits-1:0] ca;
    logic signed [CoordBits-1:0] cb;
    logic signed [CoordBits-1:0] va;
    logic signed [CoordBits-1:0] vb;
    logic signed [OverBits-1:0]  over;
    logic                        hit;
  } lane_carry_t;

  // clamp a wide signed value to one signed component
  function automatic logic [CoordBits-1:0] sat_coord(input logic signed [WideBits-1:0] v);
    logic signed [WideBits-1:0] hi;
    logic signed [WideBits-1:0] lo;
    hi = WideBits'((1 << (CoordBits - 1)) - 1);
    lo = -hi - WideBits'(1);
    if (v > hi) begin
      sat_coord = hi[CoordBits-1:0];
    end else if (v < lo) begin
      sat_coord = lo[CoordBits-1:0];
    end else begin
      sat_coord = v[CoordBits-1:0];
    end
  endfunction

endpackage

[hw/rtl/aprc_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, truncates toward zero
// depends on aprc_pkg
module aprc_div_pipe
  import aprc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [MagBits-1:0]        mag_i,
  input  logic [DenBits-1:0]        den_i,
  input  logic                      neg_i,
  input  logic                      zero_i,
  output logic signed [VcmBits-1:0] quot_o
);

  logic [MagBits-1:0]  rem_q  [DivStages];
  logic [QuotBits-1:0] qb_q   [DivStages];
  logic [DenBits-1:0]  den_q  [DivStages];
  logic                neg_q  [DivStages];
  logic                zero_q [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    localparam int B = QuotBits - 1 - g;
    logic [MagBits-1:0]  rem_in;
    logic [QuotBits-1:0] qb_in;
    logic [DenBits-1:0]  den_in;
    logic                neg_in;
    logic                zero_in;
    logic [MagBits:0]    trial;
    logic [MagBits:0]    diff;
    logic [MagBits-1:0]  rem_d;
    logic [QuotBits-1:0] qb_d;

    if (g == 0) begin : g_first
      assign rem_in  = mag_i;
      assign qb_in   = '0;
      assign den_in  = den_i;
      assign neg_in  = neg_i;
      assign zero_in = zero_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign qb_in   = qb_q[g-1];
      assign den_in  = den_q[g-1];
      assign neg_in  = neg_q[g-1];
      assign zero_in = zero_q[g-1];
    end

    // compare against the shifted divisor and subtract when it fits
    always_comb begin
      trial = (MagBits+1)'(den_in) << B;
      diff  = {1'b0, rem_in} - trial;
      qb_d  = qb_in;
      rem_d = rem_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_d = diff[MagBits-1:0];
        qb_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        qb_q[g]   <= qb_d;
        den_q[g]  <= den_in;
        neg_q[g]  <= neg_in;
        zero_q[g] <= zero_in;
      end
    end
  end

  // apply sign; zero total mass gives a zero center-of-mass velocity
  always_comb begin
    if (zero_q[DivStages-1]) begin
      quot_o = '0;
    end else if (neg_q[DivStages-1]) begin
      quot_o = -signed'({1'b0, qb_q[DivStages-1]});
    end else begin
      quot_o = signed'({1'b0, qb_q[DivStages-1]});
    end
  end

endmodule

[hw/rtl/aprc_lane.sv]
// one axis lane: extents, overlap, momentum and center-of-mass velocity
// depends on aprc_pkg and aprc_div_pipe
module aprc_lane
  import aprc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CoordBits-1:0] ca_i,
  input  logic [CoordBits-1:0] cb_i,
  input  logic [CoordBits-1:0] ha_i,
  input  logic [CoordBits-1:0] hb_i,
  input  logic [CoordBits-1:0] va_i,
  input  logic [CoordBits-1:0] vb_i,
  input  logic [MassBits-1:0]  ma_i,
  input  logic [MassBits-1:0]  mb_i,
  output lane_res_t            res_o
);

  logic signed [ExtBits-1:0]  mina, maxa, minb, maxb;
  logic signed [OverBits-1:0] over_d;
  logic                       hit_d;
  logic signed [ProdBits-1:0] pa_d, pb_d;

  // extents and overlap for this axis
  always_comb begin
    mina = ExtBits'(signed'(ca_i)) - signed'(ExtBits'(ha_i));
    maxa = ExtBits'(signed'(ca_i)) + signed'(ExtBits'(ha_i));
    minb = ExtBits'(signed'(cb_i)) - signed'(ExtBits'(hb_i));
    maxb = ExtBits'(signed'(cb_i)) + signed'(ExtBits'(hb_i));
    hit_d = (mina <= maxb) && (maxa >= minb);
    if (maxa < maxb) begin
      over_d = OverBits'(maxa) - OverBits'(minb);
    end else begin
      over_d = OverBits'(maxb) - OverBits'(mina);
    end
    pa_d = signed'({1'b0, ma_i}) * signed'(va_i);
    pb_d = signed'({1'b0, mb_i}) * signed'(vb_i);
  end

  // stage 1: products, mass sum and overlap
  lane_carry_t                s1_q;
  logic signed [ProdBits-1:0] pa_q, pb_q;
  logic [DenBits-1:0]         msum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q.ca   <= signed'(ca_i);
      s1_q.cb   <= signed'(cb_i);
      s1_q.va   <= signed'(va_i);
      s1_q.vb   <= signed'(vb_i);
      s1_q.over <= over_d;
      s1_q.hit  <= hit_d;
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      msum_q    <= DenBits'(ma_i) + DenBits'(mb_i);
    end
  end

  // stage 2: momentum sum split into sign and magnitude, total mass and zero-mass flag
  logic signed [NumBits-1:0] num;
  logic [NumBits-1:0]        num_abs;
  logic [MagBits-1:0]        mag_q;
  logic [DenBits-1:0]        den_q;
  logic                      neg_q, zero_q;

  always_comb begin
    num     = NumBits'(pa_q) + NumBits'(pb_q);
    num_abs = num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= num_abs[MagBits-1:0];
      den_q  <= msum_q;
      neg_q  <= num[NumBits-1];
      zero_q <= (msum_q == '0);
    end
  end

  logic signed [VcmBits-1:0] vcm;

  aprc_div_pipe u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .mag_i  (mag_q),
    .den_i  (den_q),
    .neg_i  (neg_q),
    .zero_i (zero_q),
    .quot_o (vcm)
  );

  // carry the axis data in step with the divider
  lane_carry_t dly_q [DlyStages];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= s1_q;
      for (int k = 1; k < DlyStages; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  always_comb begin
    res_o.ca   = dly_q[DlyStages-1].ca;
    res_o.cb   = dly_q[DlyStages-1].cb;
    res_o.va   = dly_q[DlyStages-1].va;
    res_o.vb   = dly_q[DlyStages-1].vb;
    res_o.over = dly_q[DlyStages-1].over;
    res_o.hit  = dly_q[DlyStages-1].hit;
    res_o.vcm  = vcm;
  end

endmodule

[hw/rtl/aprc_merge.sv]
// merge of the three lanes: hit, push axis, center push, velocity reflection
// depends on aprc_pkg
module aprc_merge
  import aprc_pkg::*;
(
  input  lane_res_t          lane_i [NumAxes],
  input  logic               fa_i,
  input  logic               fb_i,
  output logic               hit_o,
  output logic [VecBits-1:0] ca_o,
  output logic [VecBits-1:0] cb_o,
  output logic [VecBits-1:0] va_o,
  output logic [VecBits-1:0] vb_o,
  output push_axis_e         axis_o
);

  logic                       moving;
  logic signed [OverBits-1:0] o0, o1, o2;
  logic signed [OverBits-1:0] half;
  logic signed [WideBits-1:0] wa, wb, wva, wvb;
  logic                       push;

  // pick the strictly smallest overlap axis
  always_comb begin
    o0 = lane_i[0].over;
    o1 = lane_i[1].over;
    o2 = lane_i[2].over;
    hit_o  = lane_i[0].hit && lane_i[1].hit && lane_i[2].hit;
    moving = 1'b0;
    for (int i = 0; i < NumAxes; i++) begin
      moving = moving || (lane_i[i].va != '0) || (lane_i[i].vb != '0);
    end
    axis_o = AXIS_NONE;
    if (hit_o) begin
      priority if (o0 < o1 && o0 < o2) begin
        axis_o = AXIS_X;
      end else if (o1 < o0 && o1 < o2) begin
        axis_o = AXIS_Y;
      end else if (o2 < o1 && o2 < o0) begin
        axis_o = AXIS_Z;
      end else begin
        axis_o = AXIS_NONE;
      end
    end
  end

  // per-axis center push and velocity reflection, then saturation
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      push = (axis_o != AXIS_NONE) && (int'(axis_o) == i + 1);
      half = lane_i[i].over >>> 1;
      wa   = WideBits'(lane_i[i].ca);
      wb   = WideBits'(lane_i[i].cb);
      wva  = WideBits'(lane_i[i].va);
      wvb  = WideBits'(lane_i[i].vb);
      if (push && !fa_i) begin
        wa = WideBits'(lane_i[i].ca) + WideBits'(half);
      end
      if (push && !fb_i) begin
        wb = WideBits'(lane_i[i].cb) - WideBits'(half);
      end
      if (hit_o && moving && !fa_i) begin
        wva = (WideBits'(lane_i[i].vcm) <<< 1) - WideBits'(lane_i[i].va);
      end
      if (hit_o && moving && !fb_i) begin
        wvb = (WideBits'(lane_i[i].vcm) <<< 1) - WideBits'(lane_i[i].vb);
      end
      ca_o[i*CoordBits +: CoordBits] = sat_coord(wa);
      cb_o[i*CoordBits +: CoordBits] = sat_coord(wb);
      va_o[i*CoordBits +: CoordBits] = sat_coord(wva);
      vb_o[i*CoordBits +: CoordBits] = sat_coord(wvb);
    end
  end

endmodule

[hw/rtl/aabb_pair_collision_resolve_top.sv]
// Resolves one pair of axis-aligned boxes per beat: overlap test, push along the
// strictly smallest overlap axis and velocity reflection about the center-of-mass
// velocity. A new beat is taken every cycle while not stalled; each result
// passes through one product stage, one momentum sum stage, 16 stages of
// the restoring divider that forms the center-of-mass velocity and one output
// register. The whole pipeline stalls only while a result waits at the output.
// depends on aprc_pkg, aprc_lane, aprc_merge
module aabb_pair_collision_resolve_top
  import aprc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_a, center_b, half_a, half_b, vel_a, vel_b, mass_a, mass_b,
  // fixed_a, fixed_b, zero pad
  input  logic [InBytes*8-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit, new_center_a, new_center_b, new_vel_a, new_vel_b, push_axis, zero pad
  output logic [OutBytes*8-1:0] m_axis_tdata
);

  localparam int OffCb = VecBits;
  localparam int OffHa = 2 * VecBits;
  localparam int OffHb = 3 * VecBits;
  localparam int OffVa = 4 * VecBits;
  localparam int OffVb = 5 * VecBits;
  localparam int OffMa = 6 * VecBits;
  localparam int OffMb = OffMa + MassBits;
  localparam int OffFa = OffMb + MassBits;

  logic en;
  logic out_vld_q;
  logic [Latency-1:0] vld_q;
  logic fa_q [Latency];
  logic fb_q [Latency];

  // whole pipeline advances unless a result is stuck at the output
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], s_axis_tvalid};
    end
  end

  // static flags follow the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_q[0] <= s_axis_tdata[OffFa];
      fb_q[0] <= s_axis_tdata[OffFa+1];
      for (int k = 1; k < Latency; k++) begin
        fa_q[k] <= fa_q[k-1];
        fb_q[k] <= fb_q[k-1];
      end
    end
  end

  // one lane per axis
  lane_res_t lane_res [NumAxes];

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    aprc_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .ca_i  (s_axis_tdata[g*CoordBits +: CoordBits]),
      .cb_i  (s_axis_tdata[OffCb + g*CoordBits +: CoordBits]),
      .ha_i  (s_axis_tdata[OffHa + g*CoordBits +: CoordBits]),
      .hb_i  (s_axis_tdata[OffHb + g*CoordBits +: CoordBits]),
      .va_i  (s_axis_tdata[OffVa + g*CoordBits +: CoordBits]),
      .vb_i  (s_axis_tdata[OffVb + g*CoordBits +: CoordBits]),
      .ma_i  (s_axis_tdata[OffMa +: MassBits]),
      .mb_i  (s_axis_tdata[OffMb +: MassBits]),
      .res_o (lane_res[g])
    );
  end

  logic               hit;
  logic [VecBits-1:0] nca, ncb, nva, nvb;
  push_axis_e         axis;

  aprc_merge u_merge (
    .lane_i (lane_res),
    .fa_i   (fa_q[Latency-1]),
    .fb_i   (fb_q[Latency-1]),
    .hit_o  (hit),
    .ca_o   (nca),
    .cb_o   (ncb),
    .va_o   (nva),
    .vb_o   (nvb),
    .axis_o (axis)
  );

  // output register
  logic [OutBytes*8-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[Latency-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= (OutBytes*8)'({axis, nvb, nva, ncb, nca, hit});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_axis_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (m_axis_tdata[OutBits-1 -: 2] != AXIS_NONE) |-> m_axis_tdata[0])
    else $error("push axis set without a hit");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[Latency-1] |=> out_vld_q)
    else $error("finished beat lost before the output register");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_data_q))
    else $error("output register changed under back-pressure");

endmodule
